>>> rtl/core/rsi_pkg.sv
// Shared types and constants of the relative strength index block.
package rsi_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DEF_MAX_WINDOW = 64;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_PRICE_BITS = 32;

    // Register widths and reset values
    localparam int WL_W       = 7;
    localparam int WL_RESET   = 14;
    localparam int MIN_WINDOW = 2;

    // Result format: RSI in hundredths, 0..10000
    localparam int RSI_W     = 14;
    localparam int RSI_SCALE = 10000;

    // Configuration port
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_AVERAGE_MODE  = 1'd1;

    localparam logic MODE_SMOOTHED = 1'b0;
    localparam logic MODE_STANDARD = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic in_ready;
        logic change;
        logic update;
        logic avg_start;
        logic ratio_prep;
        logic ratio_start;
        logic emit;
    } rsi_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic series_start;
        logic avg_needed;
        logic avg_done;
        logic den_zero;
        logic ratio_done;
        logic out_free;
    } rsi_status_t;

endpackage

>>> rtl/core/rsi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rsi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> rtl/core/rsi_div.sv
// Restoring divider, one quotient bit per cycle; quotient must fit QUO_W bits.
module rsi_div #(
    parameter int DVD_W = 55,
    parameter int DVS_W = 7,
    parameter int QUO_W = 48
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);
    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(QUO_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [QUO_W-1:0] quo_reg;

    logic [DVS_W:0]   trial;
    logic             fits;

    // Trial subtract of the divisor from the partial remainder
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient; low dividend bits shift out as quotient bits shift in
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DVS_W'(dividend[DVD_W-1:QUO_W]);
            quo_reg <= dividend[QUO_W-1:0];
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

>>> rtl/core/rsi_ctrl.sv
// Sequencer that steps one price request through the datapath.
module rsi_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  rsi_pkg::rsi_status_t status,
    output rsi_pkg::rsi_cmd_t    cmd
);
    import rsi_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHANGE,
        ST_UPDATE,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_RATIO_PREP,
        ST_RATIO_START,
        ST_RATIO_WAIT,
        ST_EMIT
    } state_t;

    state_t   state_reg, state_next;
    rsi_cmd_t cmd_reg, cmd_next;
    rsi_cmd_t cmd_idle;

    // Idle command word: ready for a request
    always_comb begin
        cmd_idle          = '0;
        cmd_idle.in_ready = 1'b1;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:        if (s_tvalid) state_next = ST_CHANGE;
            ST_CHANGE:      state_next = status.series_start ? ST_EMIT : ST_UPDATE;
            ST_UPDATE:      state_next = status.avg_needed ? ST_AVG_START : ST_EMIT;
            ST_AVG_START:   state_next = ST_AVG_WAIT;
            ST_AVG_WAIT:    if (status.avg_done) state_next = ST_RATIO_PREP;
            ST_RATIO_PREP:  state_next = status.den_zero ? ST_EMIT : ST_RATIO_START;
            ST_RATIO_START: state_next = ST_RATIO_WAIT;
            ST_RATIO_WAIT:  if (status.ratio_done) state_next = ST_EMIT;
            ST_EMIT:        if (status.out_free) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // Commands follow the state being entered
    always_comb begin
        cmd_next = '0;
        case (state_next)
            ST_IDLE:        cmd_next.in_ready    = 1'b1;
            ST_CHANGE:      cmd_next.change      = 1'b1;
            ST_UPDATE:      cmd_next.update      = 1'b1;
            ST_AVG_START:   cmd_next.avg_start   = 1'b1;
            ST_RATIO_PREP:  cmd_next.ratio_prep  = 1'b1;
            ST_RATIO_START: cmd_next.ratio_start = 1'b1;
            ST_EMIT:        cmd_next.emit        = 1'b1;
            default:        cmd_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cmd_reg   <= cmd_idle;
        end else begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign cmd = cmd_reg;
endmodule

>>> rtl/core/rsi_dp.sv
// Datapath: price change split, running sums, change ring, averages and ratio.
module rsi_dp #(
    parameter int MAX_WINDOW = rsi_pkg::DEF_MAX_WINDOW,
    parameter int FRAC_BITS  = rsi_pkg::DEF_FRAC_BITS,
    parameter int PRICE_BITS = rsi_pkg::DEF_PRICE_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rsi_pkg::rsi_cmd_t          cmd,
    output rsi_pkg::rsi_status_t       status,
    input  logic [rsi_pkg::WL_W-1:0]   window_length,
    input  logic                       average_mode,
    input  logic                       s_tvalid,
    input  logic [PRICE_BITS-1:0]      s_price,
    input  logic                       s_restart,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic [rsi_pkg::RSI_W-1:0]  m_rsi,
    output logic                       m_valid_res
);
    import rsi_pkg::*;

    localparam int NB     = $clog2(MAX_WINDOW + 1);
    localparam int SLOT_W = $clog2(MAX_WINDOW);
    localparam int AVG_W  = PRICE_BITS + FRAC_BITS;
    localparam int SUM_W  = PRICE_BITS + NB;
    localparam int NUM_W  = AVG_W + NB;
    localparam int RNUM_W = AVG_W + RSI_W;
    localparam int RING_W = 2 * PRICE_BITS;

    logic                  load;

    // Request and series state
    logic [PRICE_BITS-1:0] price_in_reg;
    logic                  restart_in_reg;
    logic [PRICE_BITS-1:0] last_price_reg;
    logic                  have_price_reg;
    logic [NB-1:0]         series_n_reg;
    logic [NB-1:0]         change_count_reg;
    logic [SLOT_W-1:0]     ring_slot_reg;
    logic [SUM_W-1:0]      gain_sum_reg, loss_sum_reg;
    logic [AVG_W-1:0]      avg_gain_reg, avg_loss_reg;
    logic [PRICE_BITS-1:0] gain_reg, loss_reg;

    // Divider operands and result
    logic [NUM_W-1:0]      num_gain_reg, num_loss_reg;
    logic [RNUM_W-1:0]     ratio_num_reg;
    logic [AVG_W:0]        ratio_den_reg;
    logic [RSI_W-1:0]      res_rsi_reg;
    logic                  res_valid_reg;

    // Output register
    logic                  m_tvalid_reg;
    logic [RSI_W-1:0]      m_rsi_reg;
    logic                  m_valid_res_reg;

    logic [RING_W-1:0]     ring_rdata;
    logic [PRICE_BITS-1:0] old_gain, old_loss;
    logic [NB-1:0]         n_clamp;
    logic                  warm;
    logic [NB-1:0]         count_inc;
    logic [NB-1:0]         slot_inc;
    logic [SUM_W-1:0]      gain_sum_new, loss_sum_new;
    logic [NUM_W-1:0]      num_gain_new, num_loss_new;
    logic                  avg_needed;
    logic                  out_free;

    logic                  gdiv_done, ldiv_done, rdiv_done;
    logic [AVG_W-1:0]      gdiv_quo, ldiv_quo;
    logic [RSI_W-1:0]      rdiv_quo;

    assign load     = s_tvalid & cmd.in_ready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign old_gain = ring_rdata[PRICE_BITS-1:0];
    assign old_loss = ring_rdata[RING_W-1:PRICE_BITS];

    // Window length clamped to the supported range
    always_comb begin
        if (window_length < WL_W'(MIN_WINDOW)) begin
            n_clamp = NB'(MIN_WINDOW);
        end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
            n_clamp = NB'(MAX_WINDOW);
        end else begin
            n_clamp = NB'(window_length);
        end
    end

    // Sum update and divider numerators for one change
    always_comb begin
        warm      = change_count_reg < series_n_reg;
        count_inc = change_count_reg + 1'b1;
        slot_inc  = NB'(ring_slot_reg) + 1'b1;
        if (warm) begin
            gain_sum_new = gain_sum_reg + SUM_W'(gain_reg);
            loss_sum_new = loss_sum_reg + SUM_W'(loss_reg);
        end else begin
            gain_sum_new = gain_sum_reg - SUM_W'(old_gain) + SUM_W'(gain_reg);
            loss_sum_new = loss_sum_reg - SUM_W'(old_loss) + SUM_W'(loss_reg);
        end
        avg_needed = !warm || (count_inc == series_n_reg);
        if (!warm && average_mode == MODE_SMOOTHED) begin
            // Wilder: (avg*(n-1) + change) / n
            num_gain_new = NUM_W'(avg_gain_reg) * NUM_W'(series_n_reg - 1'b1)
                         + NUM_W'({gain_reg, {FRAC_BITS{1'b0}}});
            num_loss_new = NUM_W'(avg_loss_reg) * NUM_W'(series_n_reg - 1'b1)
                         + NUM_W'({loss_reg, {FRAC_BITS{1'b0}}});
        end else begin
            num_gain_new = {gain_sum_new, {FRAC_BITS{1'b0}}};
            num_loss_new = {loss_sum_new, {FRAC_BITS{1'b0}}};
        end
    end

    // Control-like state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_price_reg   <= 1'b0;
            change_count_reg <= '0;
            ring_slot_reg    <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cmd.change && (restart_in_reg || !have_price_reg)) begin
                have_price_reg   <= 1'b1;
                change_count_reg <= '0;
                ring_slot_reg    <= '0;
            end
            if (cmd.update) begin
                if (warm) begin
                    change_count_reg <= count_inc;
                end
                ring_slot_reg <= (slot_inc == series_n_reg) ? '0 : SLOT_W'(slot_inc);
            end
            if (cmd.emit && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (load) begin
            price_in_reg   <= s_price;
            restart_in_reg <= s_restart;
            res_rsi_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        // Price change, or start of a new series
        if (cmd.change) begin
            last_price_reg <= price_in_reg;
            if (restart_in_reg || !have_price_reg) begin
                avg_gain_reg <= '0;
                avg_loss_reg <= '0;
                gain_sum_reg <= '0;
                loss_sum_reg <= '0;
                series_n_reg <= n_clamp;
            end else if (price_in_reg > last_price_reg) begin
                gain_reg <= price_in_reg - last_price_reg;
                loss_reg <= '0;
            end else begin
                gain_reg <= '0;
                loss_reg <= last_price_reg - price_in_reg;
            end
        end
        if (cmd.update) begin
            gain_sum_reg <= gain_sum_new;
            loss_sum_reg <= loss_sum_new;
            num_gain_reg <= num_gain_new;
            num_loss_reg <= num_loss_new;
        end
        if (gdiv_done) begin
            avg_gain_reg <= gdiv_quo;
        end
        if (ldiv_done) begin
            avg_loss_reg <= ldiv_quo;
        end
        // Ratio operands: 10000*AG over AG+AL
        if (cmd.ratio_prep) begin
            ratio_num_reg <= RNUM_W'(avg_gain_reg) * RNUM_W'(RSI_SCALE);
            ratio_den_reg <= {1'b0, avg_gain_reg} + {1'b0, avg_loss_reg};
        end
        if (rdiv_done) begin
            res_rsi_reg   <= rdiv_quo;
            res_valid_reg <= 1'b1;
        end
        if (cmd.emit && out_free) begin
            m_rsi_reg       <= res_rsi_reg;
            m_valid_res_reg <= res_valid_reg;
        end
    end

    // Ring of the last N gains and losses
    rsi_ram #(
        .WIDTH (RING_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (ring_slot_reg),
        .wdata ({loss_reg, gain_reg}),
        .re    (load),
        .raddr (ring_slot_reg),
        .rdata (ring_rdata)
    );

    // Average dividers, gain and loss side by side
    rsi_div #(
        .DVD_W (NUM_W),
        .DVS_W (NB),
        .QUO_W (AVG_W)
    ) u_gain_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.avg_start),
        .dividend (num_gain_reg),
        .divisor  (series_n_reg),
        .done     (gdiv_done),
        .quotient (gdiv_quo)
    );

    rsi_div #(
        .DVD_W (NUM_W),
        .DVS_W (NB),
        .QUO_W (AVG_W)
    ) u_loss_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.avg_start),
        .dividend (num_loss_reg),
        .divisor  (series_n_reg),
        .done     (ldiv_done),
        .quotient (ldiv_quo)
    );

    // Final ratio divider
    rsi_div #(
        .DVD_W (RNUM_W),
        .DVS_W (AVG_W + 1),
        .QUO_W (RSI_W)
    ) u_ratio_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.ratio_start),
        .dividend (ratio_num_reg),
        .divisor  (ratio_den_reg),
        .done     (rdiv_done),
        .quotient (rdiv_quo)
    );

    assign status.series_start = restart_in_reg || !have_price_reg;
    assign status.avg_needed   = avg_needed;
    assign status.avg_done     = gdiv_done;
    assign status.den_zero     = (avg_gain_reg == '0) && (avg_loss_reg == '0);
    assign status.ratio_done   = rdiv_done;
    assign status.out_free     = out_free;

    assign m_tvalid    = m_tvalid_reg;
    assign m_rsi       = m_rsi_reg;
    assign m_valid_res = m_valid_res_reg;
endmodule

>>> rtl/core/relative_strength_index.sv
// Relative strength index over a price stream; top level with register port.
// One request is in work at a time, so a new one is taken only once the previous result
// has moved into the output register; the bit-serial average and ratio dividers set the rate.
// Reset (aresetn low, synchronous) clears control state and loads register defaults.
module relative_strength_index #(
    parameter int MAX_WINDOW = rsi_pkg::DEF_MAX_WINDOW,
    parameter int FRAC_BITS  = rsi_pkg::DEF_FRAC_BITS,
    parameter int PRICE_BITS = rsi_pkg::DEF_PRICE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Price requests
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((PRICE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // [PRICE_BITS-1:0] price
    input  logic [0:0]                          s_tuser,  // [0] restart
    // Results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,  // [13:0] rsi_hundredths
    output logic [0:0]                          m_tuser,  // [0] valid_res
    // Register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rsi_pkg::APB_AW-1:0]          paddr,
    input  logic [rsi_pkg::APB_DW-1:0]          pwdata,
    output logic [rsi_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);
    import rsi_pkg::*;

    logic [WL_W-1:0]      window_length_reg;
    logic                 average_mode_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    rsi_cmd_t             cmd;
    rsi_status_t          status;
    logic [RSI_W-1:0]     m_rsi;
    logic                 m_valid_res;

    // Register access
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_AW-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= WL_W'(WL_RESET);
            average_mode_reg  <= MODE_SMOOTHED;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_WINDOW_LENGTH: window_length_reg <= pwdata[WL_W-1:0];
                REG_AVERAGE_MODE:  average_mode_reg  <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WINDOW_LENGTH: prdata = APB_DW'(window_length_reg);
            REG_AVERAGE_MODE:  prdata = APB_DW'(average_mode_reg);
            default:           prdata = '0;
        endcase
    end

    rsi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    rsi_dp #(
        .MAX_WINDOW (MAX_WINDOW),
        .FRAC_BITS  (FRAC_BITS),
        .PRICE_BITS (PRICE_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .window_length (window_length_reg),
        .average_mode  (average_mode_reg),
        .s_tvalid      (s_tvalid),
        .s_price       (s_tdata[PRICE_BITS-1:0]),
        .s_restart     (s_tuser[0]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_rsi         (m_rsi),
        .m_valid_res   (m_valid_res)
    );

    assign s_tready = cmd.in_ready;
    assign m_tdata  = 16'(m_rsi);
    assign m_tuser  = m_valid_res;
endmodule

>>> dv/tb.sv
// Self-checking testbench for the relative strength index block: stream stimulus and prediction.
module tb;
    import rsi_pkg::*;

    localparam int     MAX_WIN   = DEF_MAX_WINDOW;
    localparam int     HIST_W    = $clog2(MAX_WIN);
    localparam int     FRAC      = DEF_FRAC_BITS;
    localparam longint PRICE_MAX = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] price;
        logic        restart;
    } price_req_t;

    typedef struct packed {
        logic [RSI_W-1:0] rsi;
        logic             ok;
    } rsi_res_t;

    // Clock, reset and block ports
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] price
    logic [0:0]  s_tuser = '0;   // [0] restart
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [13:0] rsi_hundredths
    logic [0:0]  m_tuser;        // [0] valid_res
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic        pready;

    // Request queue, expected results and run control
    price_req_t  price_pending[$];
    rsi_res_t    rsi_due[$];
    price_req_t  next_req;
    rsi_res_t    due_now;
    logic        price_taken = 1'b0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          hold_go = 1'b0;
    int          hold_left = 0;
    int          fail_count = 0;
    int          req_count = 0;
    int          res_count = 0;

    // Predictor copy of registers and series state
    logic [WL_W-1:0] cfg_window = WL_W'(WL_RESET);
    logic            cfg_mode = MODE_SMOOTHED;
    logic [31:0]     prev_price = '0;
    bit              series_open = 1'b0;
    int unsigned     seen_changes = 0;
    logic [63:0]     gain_avg = '0;
    logic [63:0]     loss_avg = '0;
    logic [63:0]     gain_total = '0;
    logic [63:0]     loss_total = '0;
    logic [31:0]     gain_hist[MAX_WIN];
    logic [31:0]     loss_hist[MAX_WIN];
    int unsigned     hist_pos = 0;
    int unsigned     series_len = WL_RESET;

    relative_strength_index dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned clamp_len(input logic [WL_W-1:0] v);
        if (32'(v) < MIN_WINDOW) return MIN_WINDOW;
        if (32'(v) > MAX_WIN) return MAX_WIN;
        return 32'(v);
    endfunction

    // Expected RSI for one accepted price; advances the series state
    function automatic rsi_res_t rsi_predict(input logic [31:0] price, input logic restart);
        logic [63:0] up;
        logic [63:0] down;
        logic [63:0] n;
        logic [63:0] den;
        int unsigned slot;
        logic [HIST_W-1:0] slot_idx;
        bit          ready;
        rsi_res_t    r;
        r = '0;
        up = '0;
        down = '0;
        ready = 1'b0;
        if (restart || !series_open) begin
            prev_price = price;
            series_open = 1'b1;
            seen_changes = 0;
            gain_avg = '0;
            loss_avg = '0;
            gain_total = '0;
            loss_total = '0;
            hist_pos = 0;
            series_len = clamp_len(cfg_window);
            return r;
        end
        if (price > prev_price) up = 64'(price) - 64'(prev_price);
        else down = 64'(prev_price) - 64'(price);
        prev_price = price;
        n = 64'(series_len);
        slot = hist_pos % series_len;
        slot_idx = slot[HIST_W-1:0];
        if (seen_changes < series_len) begin
            // warm-up: plain sums until the window is full
            gain_total += up;
            loss_total += down;
            seen_changes++;
            if (seen_changes == series_len) begin
                gain_avg = (gain_total << FRAC) / n;
                loss_avg = (loss_total << FRAC) / n;
                ready = 1'b1;
            end
        end else begin
            // window sums always track the ring, whatever the mode
            gain_total = gain_total - 64'(gain_hist[slot_idx]) + up;
            loss_total = loss_total - 64'(loss_hist[slot_idx]) + down;
            if (cfg_mode == MODE_SMOOTHED) begin
                gain_avg = (gain_avg * (n - 1) + (up << FRAC)) / n;
                loss_avg = (loss_avg * (n - 1) + (down << FRAC)) / n;
            end else begin
                gain_avg = (gain_total << FRAC) / n;
                loss_avg = (loss_total << FRAC) / n;
            end
            ready = 1'b1;
        end
        gain_hist[slot_idx] = up[31:0];
        loss_hist[slot_idx] = down[31:0];
        hist_pos = (slot + 1) % series_len;
        if (ready) begin
            den = gain_avg + loss_avg;
            if (den != 0) begin
                r.rsi = RSI_W'((gain_avg * RSI_SCALE) / den);
                r.ok = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < 40) $display("mismatch: %s got %0d want %0d", what, got, want);
        fail_count++;
    endtask

    // Request driver: hold until taken, then maybe idle, else present the next price
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || price_taken) begin
            if (price_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_req = price_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_req.price;
                s_tuser  <= next_req.restart;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off counter
    always @(negedge aclk) begin
        if (hold_go) hold_left <= 400;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    // Result ready with random stalls
    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end

    // Monitor: check results against the oldest expectation, then predict new requests
    always @(posedge aclk) begin
        if (!aresetn) begin
            price_taken <= 1'b0;
        end else begin
            price_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                res_count++;
                if (rsi_due.size() == 0) begin
                    report_mismatch("result with nothing pending", 32'(m_tdata), 0);
                end else begin
                    due_now = rsi_due.pop_front();
                    if (m_tdata[RSI_W-1:0] !== due_now.rsi)
                        report_mismatch("rsi_hundredths", 32'(m_tdata[RSI_W-1:0]),
                                        32'(due_now.rsi));
                    if (m_tuser[0] !== due_now.ok)
                        report_mismatch("valid_res", 32'(m_tuser[0]), 32'(due_now.ok));
                end
            end
            if (s_tvalid && s_tready) rsi_due.push_back(rsi_predict(s_tdata, s_tuser[0]));
        end
    end

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (idx == REG_WINDOW_LENGTH) cfg_window = value[WL_W-1:0];
        else if (idx == REG_AVERAGE_MODE) cfg_mode = value[0];
    endtask

    task automatic push_price(input logic [31:0] price, input logic restart);
        price_pending.push_back('{price: price, restart: restart});
        req_count++;
    endtask

    // Wait until every request is taken and every result has arrived
    task automatic wait_drained();
        @(negedge aclk);
        while (res_count != req_count)
            @(negedge aclk);
    endtask

    // One price series with a random trend shape
    task automatic push_series(input int len, input bit fresh);
        longint level;
        int     kind;
        int     k;
        level = longint'($urandom);
        kind = $urandom_range(0, 4);
        for (k = 0; k < len; k++) begin
            case (kind)
                0: level += longint'($urandom_range(0, 4000)) - 2000;
                1: level += longint'($urandom) - longint'($urandom);
                2: level += longint'($urandom_range(0, 5000));   // rising: no losses
                3: ;                                             // flat: no change at all
                default: begin
                    if ($urandom_range(9) == 0) level = $urandom_range(1) ? PRICE_MAX : 0;
                    else level = longint'($urandom);
                end
            endcase
            if (level < 0) level = 0;
            if (level > PRICE_MAX) level = PRICE_MAX;
            push_price(level[31:0], (k == 0) && fresh);
        end
    endtask

    // Random block of series under one register setting
    task automatic run_block(input int window, input int mode, input int count,
                             input bit pressure);
        int pushed;
        int n_eff;
        int len;
        int pick;
        bit first;
        reg_write(REG_WINDOW_LENGTH, window);
        reg_write(REG_AVERAGE_MODE, mode);
        n_eff = clamp_len(window[WL_W-1:0]);
        pushed = 0;
        first = 1'b1;
        while (pushed < count) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                // lone restart as noise
                push_price($urandom, 1'b1);
                pushed++;
            end else begin
                // mostly full series; some cut short inside warm-up
                len = (pick < 20) ? $urandom_range(1, n_eff) : n_eff + $urandom_range(1, 40);
                push_series(len, !(first && $urandom_range(2) == 0));
                pushed += len;
            end
            first = 1'b0;
        end
        if (pressure) begin
            @(posedge aclk);
            hold_go = 1'b1;
            @(posedge aclk);
            hold_go = 1'b0;
        end
        wait_drained();
    endtask

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: shortest window, smoothed; first price after reset opens a series
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        reg_write(REG_WINDOW_LENGTH, 2);
        reg_write(REG_AVERAGE_MODE, MODE_SMOOTHED);
        push_price(32'd0, 1'b0);
        push_price(32'd0, 1'b0);          // warm-up
        push_price(32'd0, 1'b0);          // both averages zero
        push_price(32'hFFFF_FFFF, 1'b0);  // largest gain, no loss
        push_price(32'd0, 1'b0);          // largest loss
        push_price(32'd5, 1'b1);
        push_price(32'd10, 1'b0);
        push_price(32'd20, 1'b0);         // zero average loss
        push_price(32'd15, 1'b0);
        wait_drained();

        // Switch to the sliding mean in the middle of the series
        reg_write(REG_AVERAGE_MODE, MODE_STANDARD);
        push_price(32'd30, 1'b0);
        push_price(32'd30, 1'b0);
        push_price(32'hFFFF_FFFF, 1'b0);
        push_price(32'd0, 1'b0);
        wait_drained();

        // Window above range: ignored until restart, then clamped to the largest
        reg_write(REG_WINDOW_LENGTH, 127);
        reg_write(REG_AVERAGE_MODE, MODE_SMOOTHED);
        push_price(32'd100, 1'b0);
        push_price(32'd200, 1'b0);
        push_price(32'd7, 1'b1);
        push_price(32'd8, 1'b0);
        push_price(32'd9, 1'b0);
        wait_drained();

        // Window below range counts as the smallest
        reg_write(REG_WINDOW_LENGTH, 1);
        push_price(32'd50, 1'b1);
        push_price(32'd40, 1'b0);
        push_price(32'd40, 1'b0);
        push_price(32'd60, 1'b0);
        wait_drained();

        // Random: light sender idling, heavy receiver stalls
        tx_idle_pct = 20;
        rx_idle_pct = 71;
        run_block(2, MODE_SMOOTHED, 60, 1'b0);
        run_block(9, MODE_STANDARD, 60, 1'b1);
        run_block(14, MODE_SMOOTHED, 60, 1'b0);

        // Random: heavy sender idling, light receiver stalls
        tx_idle_pct = 71;
        rx_idle_pct = 20;
        run_block(64, MODE_STANDARD, 50, 1'b0);
        run_block(0, MODE_STANDARD, 50, 1'b0);
        run_block(127, MODE_SMOOTHED, 50, 1'b0);

        // Random: back to back
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_block(33, MODE_STANDARD, 50, 1'b0);
        run_block(64, MODE_SMOOTHED, 50, 1'b0);

        // Tail: catch stray results
        repeat (200) @(negedge aclk);
        if (rsi_due.size() != 0) report_mismatch("results never delivered", rsi_due.size(), 0);
        if (fail_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
